@@ sv/becn_pkg.sv @@
// Package with shared constants and types of the bubble elementary check node.
package becn_pkg;

    localparam int LIST_SIZE    = 16;
    localparam int GF_SIZE      = 64;
    localparam int LLR_BITS     = 8;
    localparam int SYM_BITS     = 6;
    localparam int NUM_BUBBLES  = 8;
    localparam int HALF_BUBBLES = 4;
    localparam int IDX_BITS     = $clog2(LIST_SIZE);
    localparam int POS_BITS     = $clog2(LIST_SIZE + 1);
    localparam int SUM_BITS     = LLR_BITS + 1;
    localparam int BUB_BITS     = $clog2(NUM_BUBBLES);
    localparam int QUEUE_DEPTH  = 2;
    localparam logic [SUM_BITS-1:0] EMPTY_LLR = '1;
    localparam logic [LLR_BITS-1:0] LLR_MAX   = '1;

    typedef struct packed {
        logic [LLR_BITS-1:0] llr;
        logic [SYM_BITS-1:0] sym;
        logic                ok;
    } entry_t;

    // One list position as it travels from the front to the back.
    typedef struct packed {
        entry_t a;
        entry_t b;
        logic   store;
        logic   last;
    } load_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PICK,
        ST_EVAL,
        ST_SUM,
        ST_DRAIN
    } state_t;

endpackage

@@ sv/becn_front.sv @@
// Front part: accepts list items, counts the load position and marks overflow items so they are not stored.
module becn_front
    import becn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          q_full,
    input  logic [7:0]    llr_a,
    input  logic [5:0]    symbol_a,
    input  logic          valid_a,
    input  logic [7:0]    llr_b,
    input  logic [5:0]    symbol_b,
    input  logic          valid_b,
    input  logic          last_entry,
    output logic          take,
    output load_t         item
);
    logic [POS_BITS-1:0] count_reg, count_next;

    assign take = start && !q_full;

    always_comb
    begin
        item.a     = '{llr: llr_a, sym: symbol_a, ok: valid_a};
        item.b     = '{llr: llr_b, sym: symbol_b, ok: valid_b};
        item.store = (count_reg < POS_BITS'(LIST_SIZE));
        item.last  = last_entry;
        count_next = count_reg;
        if (take)
        begin
            if (last_entry)
                count_next = '0;
            else if (item.store)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end
endmodule

@@ sv/becn_queue.sv @@
// Short queue between the front and the back.
module becn_queue
    import becn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  load_t push_data,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output load_t head
);
    load_t mem_reg [QUEUE_DEPTH];
    logic  wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ sv/becn_back.sv @@
// Back part: stores the lists, runs the bubble rounds and emits the results.
module becn_back
    import becn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    max_operations,
    input  logic          q_valid,
    input  load_t         q_head,
    output logic          q_pop,
    output logic          idle,
    output logic [8:0]    out_llr,
    output logic [5:0]    out_symbol,
    output logic          out_valid,
    output logic          out_last,
    output logic          out_strobe
);
    entry_t list_a [LIST_SIZE];
    entry_t list_b [LIST_SIZE];
    logic [SUM_BITS+SYM_BITS-1:0] res_mem [LIST_SIZE];

    state_t state_reg, state_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] filled_reg, filled_next;
    logic [7:0] ops_reg, ops_next;
    logic [BUB_BITS:0] init_reg, init_next;
    logic [BUB_BITS-1:0] cur_reg, cur_next;
    logic [IDX_BITS:0] drain_reg, drain_next;
    logic [SUM_BITS-1:0] sum_reg [NUM_BUBBLES];
    logic [SUM_BITS-1:0] sum_next [NUM_BUBBLES];
    logic [IDX_BITS-1:0] row_reg [NUM_BUBBLES];
    logic [IDX_BITS-1:0] row_next [NUM_BUBBLES];
    logic [IDX_BITS-1:0] col_reg [NUM_BUBBLES];
    logic [IDX_BITS-1:0] col_next [NUM_BUBBLES];
    logic [GF_SIZE-1:0]  seen_reg, seen_next;
    logic                out_go_reg, out_go_next;
    logic                out_ok_reg, out_ok_next;
    logic                out_last_reg, out_last_next;

    // Registered list reads for the bubble under work and the result read for the drain.
    entry_t              rd_a_reg, rd_b_reg;
    logic                in_a_reg, in_b_reg;
    logic [SUM_BITS+SYM_BITS-1:0] res_rd_reg;

    logic [IDX_BITS-1:0] rd_row, rd_col;
    logic                store_we, res_we;
    logic [SYM_BITS-1:0] xsym;
    logic [SUM_BITS-1:0] rd_sum;
    logic [BUB_BITS-1:0] best;
    logic [BUB_BITS-1:0] m1_idx [NUM_BUBBLES/2];
    logic [SUM_BITS-1:0] m1_sum [NUM_BUBBLES/2];
    logic [BUB_BITS-1:0] m2_idx [NUM_BUBBLES/4];
    logic [SUM_BITS-1:0] m2_sum [NUM_BUBBLES/4];

    assign xsym   = rd_a_reg.sym ^ rd_b_reg.sym;
    // A position beyond the loaded part of a list counts with all-ones reliability.
    assign rd_sum = (in_a_reg ? {1'b0, rd_a_reg.llr} : {1'b0, LLR_MAX})
                  + (in_b_reg ? {1'b0, rd_b_reg.llr} : {1'b0, LLR_MAX});

    // Minimum search as a tree; the right side wins only when strictly smaller,
    // so the lowest bubble index wins ties.
    always_comb
    begin
        for (int i = 0; i < NUM_BUBBLES/2; i++)
        begin
            if (sum_reg[2*i+1] < sum_reg[2*i])
            begin
                m1_idx[i] = BUB_BITS'(2*i+1);
                m1_sum[i] = sum_reg[2*i+1];
            end
            else
            begin
                m1_idx[i] = BUB_BITS'(2*i);
                m1_sum[i] = sum_reg[2*i];
            end
        end
        for (int i = 0; i < NUM_BUBBLES/4; i++)
        begin
            if (m1_sum[2*i+1] < m1_sum[2*i])
            begin
                m2_idx[i] = m1_idx[2*i+1];
                m2_sum[i] = m1_sum[2*i+1];
            end
            else
            begin
                m2_idx[i] = m1_idx[2*i];
                m2_sum[i] = m1_sum[2*i];
            end
        end
        best = (m2_sum[1] < m2_sum[0]) ? m2_idx[1] : m2_idx[0];
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        filled_next   = filled_reg;
        ops_next      = ops_reg;
        init_next     = init_reg;
        cur_next      = cur_reg;
        drain_next    = drain_reg;
        sum_next      = sum_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        seen_next     = seen_reg;
        out_go_next   = 1'b0;
        out_ok_next   = 1'b0;
        out_last_next = 1'b0;
        q_pop         = 1'b0;
        store_we      = 1'b0;
        res_we        = 1'b0;
        rd_row        = row_reg[cur_reg];
        rd_col        = col_reg[cur_reg];
        case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.store)
                    begin
                        store_we = 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                    if (q_head.last)
                    begin
                        state_next  = ST_INIT;
                        init_next   = '0;
                        filled_next = '0;
                        ops_next    = '0;
                        seen_next   = '0;
                    end
                end
            end
            ST_INIT:
            begin
                // The reads for bubble k go out in step k and its sum lands in step k+1.
                if (init_reg != (BUB_BITS+1)'(NUM_BUBBLES))
                begin
                    if (init_reg < (BUB_BITS+1)'(HALF_BUBBLES))
                    begin
                        rd_row = IDX_BITS'(init_reg);
                        rd_col = '0;
                    end
                    else
                    begin
                        rd_row = IDX_BITS'(HALF_BUBBLES);
                        rd_col = IDX_BITS'(init_reg - (BUB_BITS+1)'(HALF_BUBBLES));
                    end
                    row_next[init_reg[BUB_BITS-1:0]] = rd_row;
                    col_next[init_reg[BUB_BITS-1:0]] = rd_col;
                end
                if (init_reg != '0)
                    sum_next[BUB_BITS'(init_reg - 1'b1)] = rd_sum;
                if (init_reg == (BUB_BITS+1)'(NUM_BUBBLES))
                    state_next = ST_PICK;
                init_next = init_reg + 1'b1;
            end
            ST_PICK:
            begin
                if (ops_reg == max_operations)
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
                else
                begin
                    cur_next   = best;
                    rd_row     = row_reg[best];
                    rd_col     = col_reg[best];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                ops_next = ops_reg + 1'b1;
                if (!in_a_reg || !in_b_reg || !rd_a_reg.ok || !rd_b_reg.ok)
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
                else
                begin
                    if (!seen_reg[xsym])
                    begin
                        seen_next[xsym] = 1'b1;
                        res_we          = 1'b1;
                        filled_next     = filled_reg + 1'b1;
                    end
                    if (filled_next == POS_BITS'(LIST_SIZE) ||
                        row_reg[cur_reg] == IDX_BITS'(LIST_SIZE - 1) ||
                        col_reg[cur_reg] == IDX_BITS'(LIST_SIZE - 1))
                    begin
                        state_next = ST_DRAIN;
                        drain_next = '0;
                    end
                    else
                    begin
                        // Lower bubbles walk along their row, upper ones down their column.
                        if (cur_reg >= BUB_BITS'(HALF_BUBBLES))
                            row_next[cur_reg] = row_reg[cur_reg] + 1'b1;
                        else
                            col_next[cur_reg] = col_reg[cur_reg] + 1'b1;
                        rd_row     = row_next[cur_reg];
                        rd_col     = col_next[cur_reg];
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                sum_next[cur_reg] = rd_sum;
                state_next        = ST_PICK;
            end
            default:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == (IDX_BITS+1)'(LIST_SIZE))
                begin
                    state_next = ST_LOAD;
                    pos_next   = '0;
                end
                else
                begin
                    out_go_next   = 1'b1;
                    out_ok_next   = (POS_BITS'(drain_reg) < filled_reg);
                    out_last_next = (drain_reg == (IDX_BITS+1)'(LIST_SIZE - 1));
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            pos_reg      <= '0;
            filled_reg   <= '0;
            ops_reg      <= '0;
            init_reg     <= '0;
            cur_reg      <= '0;
            drain_reg    <= '0;
            seen_reg     <= '0;
            out_go_reg   <= 1'b0;
            out_ok_reg   <= 1'b0;
            out_last_reg <= 1'b0;
            for (int i = 0; i < NUM_BUBBLES; i++)
            begin
                sum_reg[i] <= '0;
                row_reg[i] <= '0;
                col_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            filled_reg   <= filled_next;
            ops_reg      <= ops_next;
            init_reg     <= init_next;
            cur_reg      <= cur_next;
            drain_reg    <= drain_next;
            seen_reg     <= seen_next;
            out_go_reg   <= out_go_next;
            out_ok_reg   <= out_ok_next;
            out_last_reg <= out_last_next;
            for (int i = 0; i < NUM_BUBBLES; i++)
            begin
                sum_reg[i] <= sum_next[i];
                row_reg[i] <= row_next[i];
                col_reg[i] <= col_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            list_a[pos_reg[IDX_BITS-1:0]] <= q_head.a;
            list_b[pos_reg[IDX_BITS-1:0]] <= q_head.b;
        end
        if (res_we)
            res_mem[filled_reg[IDX_BITS-1:0]] <= {sum_reg[cur_reg], xsym};
        rd_a_reg   <= list_a[rd_row];
        rd_b_reg   <= list_b[rd_col];
        in_a_reg   <= (POS_BITS'(rd_row) < pos_reg);
        in_b_reg   <= (POS_BITS'(rd_col) < pos_reg);
        res_rd_reg <= res_mem[drain_reg[IDX_BITS-1:0]];
    end

    assign idle       = (state_reg == ST_LOAD);
    assign out_strobe = out_go_reg;
    assign out_valid  = out_ok_reg;
    assign out_last   = out_last_reg;
    assign out_llr    = out_ok_reg ? res_rd_reg[SUM_BITS+SYM_BITS-1:SYM_BITS] : EMPTY_LLR;
    assign out_symbol = out_ok_reg ? res_rd_reg[SYM_BITS-1:0] : '0;
endmodule

@@ sv/bubble_elementary_check_node_unit.sv @@
// Top level of the bubble elementary check node.
//
//  channel   signals                          handshake
//  input     start, busy, llr_a..last_entry   taken when start && !busy
//  config    cfg_valid, cfg_ready, cfg_data   written when valid && ready
//  result    out_strobe, out_llr..out_last    one cycle each, no back pressure
//
// List items are taken one per cycle while busy is low and pass a two-entry queue
// before they are stored. Once the last item is stored, the eight bubbles are set up
// and each round runs through pick, list read and sum update; the round that ends
// the run skips the sum update, and max_operations ends a run in the pick step.
// Sixteen results then leave on consecutive cycles, the first in the cycle after the
// drain starts. busy stays high from the last item to the final result; the receiver
// cannot stall. Reset restores max_operations to 32 and empties the load count.
module bubble_elementary_check_node_unit
    import becn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] llr_a,
    input  logic [5:0] symbol_a,
    input  logic       valid_a,
    input  logic [7:0] llr_b,
    input  logic [5:0] symbol_b,
    input  logic       valid_b,
    input  logic       last_entry,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic [8:0] out_llr,
    output logic [5:0] out_symbol,
    output logic       out_valid,
    output logic       out_last,
    output logic       out_strobe
);
    logic [7:0] max_ops_reg;
    logic       take, q_full, q_valid, q_pop, idle;
    load_t      item, head;
    logic       run_reg;

    // The register may change only while no run is under way.
    assign cfg_ready = idle && !run_reg;
    // Stop taking items while the queue is full, and once a run is queued until its results are gone.
    assign busy = q_full || run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ops_reg <= 8'd32;
            run_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_ops_reg <= cfg_data;
            if (take && last_entry)
                run_reg <= 1'b1;
            else if (out_strobe && out_last)
                run_reg <= 1'b0;
        end
    end

    becn_front u_front (
        .clk, .rst_n, .start(start && !run_reg), .q_full,
        .llr_a, .symbol_a, .valid_a, .llr_b, .symbol_b, .valid_b, .last_entry,
        .take, .item
    );

    becn_queue u_queue (
        .clk, .rst_n, .push(take), .push_data(item), .pop(q_pop),
        .full(q_full), .not_empty(q_valid), .head
    );

    becn_back u_back (
        .clk, .rst_n, .max_operations(max_ops_reg), .q_valid, .q_head(head),
        .q_pop, .idle,
        .out_llr, .out_symbol, .out_valid, .out_last, .out_strobe
    );
endmodule

@@ sv/becn_checker.sv @@
// Port checker for the bubble elementary check node, bound to the top level.
module becn_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic out_strobe,
    input logic out_valid,
    input logic out_last,
    input logic [8:0] out_llr,
    input logic [5:0] out_symbol
);
    a_empty_llr: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && !out_valid |-> out_llr == 9'h1FF && out_symbol == 6'd0)
        else $error("empty slot not marked");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && out_last |=> !out_strobe)
        else $error("result after last");
    a_no_valid_after_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && !out_valid && !out_last |=> !(out_strobe && out_valid))
        else $error("filled slot after empty slot");
    a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && !out_last |=> out_strobe)
        else $error("gap inside the results of a run");
    a_busy_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> busy)
        else $error("input open while results leave");
endmodule

bind bubble_elementary_check_node_unit becn_checker u_becn_checker (
    .clk, .rst_n, .busy, .out_strobe, .out_valid, .out_last,
    .out_llr, .out_symbol
);

@@ tb/bubble_elementary_check_node_unit_tb.sv @@
// Self-checking testbench of the bubble elementary check node with its own list predictor.
module bubble_elementary_check_node_unit_tb;
    import becn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [8:0] llr;
        logic [5:0] sym;
        logic       ok;
        logic       last;
    } slot_t;

    typedef struct {
        logic [7:0] la;
        logic [5:0] sa;
        logic       va;
        logic [7:0] lb;
        logic [5:0] sb;
        logic       vb;
        logic       last;
    } item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] llr_a = '0;
    logic [5:0] symbol_a = '0;
    logic       valid_a = 1'b0;
    logic [7:0] llr_b = '0;
    logic [5:0] symbol_b = '0;
    logic       valid_b = 1'b0;
    logic       last_entry = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;
    logic [8:0] out_llr;
    logic [5:0] out_symbol;
    logic       out_valid;
    logic       out_last;
    logic       out_strobe;

    bubble_elementary_check_node_unit dut (.*);

    always #5 clk = ~clk;

    // Predictor state.
    logic [7:0] list_a_llr [LIST_SIZE];
    logic [5:0] list_a_sym [LIST_SIZE];
    logic       list_a_ok  [LIST_SIZE];
    logic [7:0] list_b_llr [LIST_SIZE];
    logic [5:0] list_b_sym [LIST_SIZE];
    logic       list_b_ok  [LIST_SIZE];
    int         loaded;
    logic [7:0] max_ops;

    slot_t expected_slots[$];
    int    errors;
    int    runs_done;
    int    results_seen;
    int    send_idle_pct;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [8:0] pair_llr_sum(input int r, input int c);
        logic [8:0] x, y;
        x = (r < loaded) ? {1'b0, list_a_llr[r]} : {1'b0, LLR_MAX};
        y = (c < loaded) ? {1'b0, list_b_llr[c]} : {1'b0, LLR_MAX};
        return x + y;
    endfunction

    task automatic predict_run();
        int         row [NUM_BUBBLES];
        int         col [NUM_BUBBLES];
        logic [8:0] sum [NUM_BUBBLES];
        bit         seen [GF_SIZE];
        slot_t      res [LIST_SIZE];
        int         filled, pos, r, c;
        logic [5:0] s;
        filled = 0;
        foreach (seen[i]) seen[i] = 0;
        foreach (res[i]) res[i] = '{9'h1FF, 6'd0, 1'b0, i == LIST_SIZE - 1};
        for (int b = 0; b < NUM_BUBBLES; b++) begin
            row[b] = (b < HALF_BUBBLES) ? b : HALF_BUBBLES;
            col[b] = (b < HALF_BUBBLES) ? 0 : b - HALF_BUBBLES;
            sum[b] = pair_llr_sum(row[b], col[b]);
        end
        for (int op = 0; op < max_ops; op++) begin
            pos = 0;
            for (int b = 1; b < NUM_BUBBLES; b++)
                if (sum[b] < sum[pos]) pos = b;
            r = row[pos];
            c = col[pos];
            if (r >= loaded || c >= loaded || !list_a_ok[r] || !list_b_ok[c]) break;
            s = list_a_sym[r] ^ list_b_sym[c];
            if (!seen[s]) begin
                seen[s] = 1;
                res[filled].llr = sum[pos];
                res[filled].sym = s;
                res[filled].ok = 1'b1;
                filled++;
            end
            if (filled >= LIST_SIZE) break;
            if (r >= LIST_SIZE - 1 || c >= LIST_SIZE - 1) break;
            if (pos >= HALF_BUBBLES) row[pos] = r + 1;
            else col[pos] = c + 1;
            sum[pos] = pair_llr_sum(row[pos], col[pos]);
        end
        foreach (res[i]) expected_slots.push_back(res[i]);
        loaded = 0;
    endtask

    task automatic predict_item(input item_t it);
        if (loaded < LIST_SIZE) begin
            list_a_llr[loaded] = it.la;
            list_a_sym[loaded] = it.sa;
            list_a_ok[loaded]  = it.va;
            list_b_llr[loaded] = it.lb;
            list_b_sym[loaded] = it.sb;
            list_b_ok[loaded]  = it.vb;
            loaded++;
        end
        if (it.last) predict_run();
    endtask

    // busy read right after the edge still shows its value from before the edge.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        llr_a <= it.la; symbol_a <= it.sa; valid_a <= it.va;
        llr_b <= it.lb; symbol_b <= it.sb; valid_b <= it.vb;
        last_entry <= it.last;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_item(it);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_slots.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_max_ops(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        max_ops = v;
        cfg_valid <= 1'b0;
    endtask

    // Random lists of n entries, mostly sorted; any entry may be invalid with small odds.
    task automatic send_random_list(input int n);
        item_t it;
        logic [7:0] acc_a, acc_b;
        acc_a = 8'($urandom_range(40));
        acc_b = 8'($urandom_range(40));
        for (int i = 0; i < n; i++) begin
            it.la = acc_a; it.lb = acc_b;
            it.sa = 6'($urandom); it.sb = 6'($urandom);
            it.va = ($urandom_range(15) != 0);
            it.vb = ($urandom_range(15) != 0);
            it.last = (i == n - 1);
            if ($urandom_range(9) == 0) begin
                it.la = 8'($urandom); it.lb = 8'($urandom);
            end
            send_item(it);
            acc_a = (acc_a > 8'd225) ? 8'd255 : 8'(acc_a + $urandom_range(30));
            acc_b = (acc_b > 8'd225) ? 8'd255 : 8'(acc_b + $urandom_range(30));
        end
    endtask

    // Result checker.
    always @(posedge clk) begin
        if (rst_n && out_strobe) begin
            slot_t w;
            if (expected_slots.size() == 0) begin
                report_mismatch("unexpected result, out_llr", out_llr, 0);
            end else begin
                w = expected_slots.pop_front();
                results_seen++;
                if (out_llr !== w.llr) report_mismatch("out_llr", out_llr, w.llr);
                if (out_symbol !== w.sym) report_mismatch("out_symbol", out_symbol, w.sym);
                if (out_valid !== w.ok) report_mismatch("out_valid", out_valid, w.ok);
                if (out_last !== w.last) report_mismatch("out_last", out_last, w.last);
                if (out_last === 1'b1) runs_done++;
            end
        end
    end

    // Directed rows: a, b fields and last; the first two rows carry typed expectations.
    item_t directed [] = '{
        '{8'd0, 6'd0, 1'b1, 8'd0, 6'd0, 1'b1, 1'b1},
        '{8'd255, 6'd63, 1'b1, 8'd255, 6'd63, 1'b1, 1'b1},
        '{8'd0, 6'd5, 1'b0, 8'd0, 6'd5, 1'b1, 1'b1},
        '{8'd0, 6'd1, 1'b1, 8'd0, 6'd2, 1'b1, 1'b0},
        '{8'd10, 6'd1, 1'b1, 8'd10, 6'd2, 1'b1, 1'b0},
        '{8'd20, 6'd4, 1'b1, 8'd20, 6'd8, 1'b0, 1'b1},
        '{8'd1, 6'd42, 1'b1, 8'd2, 6'd21, 1'b1, 1'b0},
        '{8'd2, 6'd0, 1'b1, 8'd3, 6'd0, 1'b1, 1'b0},
        '{8'd128, 6'd63, 1'b1, 8'd128, 6'd0, 1'b1, 1'b0},
        '{8'd255, 6'd1, 1'b1, 8'd255, 6'd1, 1'b1, 1'b1}
    };

    initial begin
        item_t it;
        slot_t w0;
        errors = 0; runs_done = 0; results_seen = 0; loaded = 0;
        max_ops = 8'd32;
        send_idle_pct = 17;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A single pair: only one symbol comes out, then the unloaded position stops the run.
        send_item(directed[0]);
        w0 = expected_slots[expected_slots.size() - LIST_SIZE];
        if (w0.llr != 9'd0 || w0.sym != 6'd0 || w0.ok != 1'b1 || w0.last != 1'b0)
            report_mismatch("predictor slot 0 llr", w0.llr, 0);
        send_item(directed[1]);
        w0 = expected_slots[expected_slots.size() - LIST_SIZE];
        if (w0.llr != 9'd510)
            report_mismatch("predictor max sum", w0.llr, 510);
        for (int i = 2; i < directed.size(); i++) send_item(directed[i]);
        wait_drained();

        // Full list, then an overflow item that carries last.
        for (int i = 0; i < LIST_SIZE + 1; i++) begin
            it = '{i[7:0] * 8'd3, i[5:0], 1'b1, i[7:0] * 8'd2, ~i[5:0], 1'b1,
                   i == LIST_SIZE};
            send_item(it);
        end
        wait_drained();

        write_max_ops(8'd0);
        send_item(directed[6]);
        send_item(directed[0]);
        wait_drained();
        write_max_ops(8'd255);
        send_random_list(LIST_SIZE);
        wait_drained();
        write_max_ops(8'd1);
        send_random_list(3);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
            write_max_ops((ph == 2) ? 8'd255 : 8'($urandom_range(4, 40)));
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(4) == 0) send_random_list(LIST_SIZE);
                else send_random_list($urandom_range(1, 10));
            end
            wait_drained();
        end

        $display("Covered %0d runs, %0d results, max_operations from 0 to 255.",
                 runs_done, results_seen);
        if (errors == 0 && expected_slots.size() == 0)
            $display("bubble_elementary_check_node_unit_tb OK");
        else
            $display("bubble_elementary_check_node_unit_tb NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("bubble_elementary_check_node_unit_tb NOT OK");
        $finish;
    end
endmodule
